// ----- design/qau_pkg.sv -----
// Shared types, opcodes and helpers for the quaternion arithmetic unit.
// No dependencies; imported by qau_hprod and quaternion_arithmetic_unit.
package qau_pkg;

    localparam int FRAC_BITS = 28;

    typedef logic signed [31:0] q_t;     // Q4.28 component
    typedef logic signed [32:0] qw_t;    // operand after exact negation
    typedef logic signed [37:0] prod_t;  // floored product
    typedef logic signed [39:0] acc_t;   // sum of four products

    typedef enum logic [1:0] {
        OP_MUL      = 2'd0,
        OP_MUL_CONJ = 2'd1,
        OP_ADD      = 2'd2,
        OP_ROTATE   = 2'd3
    } opcode_t;

    // Data carried alongside the product pipeline
    typedef struct packed {
        opcode_t    op;
        q_t [3:0]   a;
        q_t [3:0]   res;
        logic       flag;
    } side_t;

    typedef struct packed {
        q_t   val;
        logic clip;
    } sat_t;

    // Hamilton product sign pattern: bit i of row k set means term p_i*q_(i^k)
    // is subtracted from component k.
    localparam logic [3:0] HNEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    function automatic sat_t sat32(input acc_t v);
        sat_t s;
        if (v > acc_t'(32'sh7fffffff)) begin
            s.val  = 32'sh7fffffff;
            s.clip = 1'b1;
        end else if (v < -acc_t'(40'sh0080000000)) begin
            s.val  = 32'sh80000000;
            s.clip = 1'b1;
        end else begin
            s.val  = v[31:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

endpackage

// ----- design/qau_hprod.sv -----
// Two-stage Hamilton product p*q: sixteen products, then signed sums.
// Depends on qau_pkg.
module qau_hprod import qau_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  qw_t   p [4],
    input  qw_t   q [4],
    input  side_t side_in,
    output logic  out_valid,
    input  logic  out_ready,
    output acc_t  r [4],
    output side_t side_out
);

    logic  va_reg, vb_reg;
    logic  ready_a, ready_b;
    prod_t prod_reg [4][4];
    side_t side_a_reg, side_b_reg;
    acc_t  r_reg [4];
    logic signed [65:0] full [4][4];
    acc_t  sum_next [4];

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                full[i][j] = p[i] * q[j];
            end
        end
    end

    // four-term signed sum per component of the products, floor-shifted when registered
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum_next[k] = '0;
            for (int i = 0; i < 4; i++) begin
                if (HNEG[k][i]) begin
                    sum_next[k] = sum_next[k] - acc_t'(prod_reg[i][2'(i) ^ 2'(k)]);
                end else begin
                    sum_next[k] = sum_next[k] + acc_t'(prod_reg[i][2'(i) ^ 2'(k)]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ready_a) va_reg <= in_valid;
            if (ready_b) vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= full[i][j][65:FRAC_BITS];
                end
            end
            side_a_reg <= side_in;
        end
        if (ready_b && va_reg) begin
            r_reg      <= sum_next;
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign r         = r_reg;
    assign side_out  = side_b_reg;

endmodule

// ----- design/quaternion_arithmetic_unit.sv -----
// Quaternion arithmetic unit top level: operand prep, two Hamilton product
// units, saturation and output register. Depends on qau_pkg and qau_hprod.
//
// Usage:
//   Input channel s_*: one request per accepted beat (s_tvalid & s_tready).
//     s_tuser carries the opcode, s_tdata the two quaternions a and b.
//   Output channel m_*: one result per request, in request order.
//     m_tdata carries r_w..r_z, m_tuser the saturated flag.
//   Opcodes: a*b, a*conj(b), a+b, and rotation a*v*conj(a) of v = b_x..b_z.
//   Order: all requests take the same path (prep, product unit, saturate,
//     product unit, output) from acceptance to m_tvalid, for every opcode,
//     so results never reorder.
//   Throughput: one request per cycle, sustained while m_tready is high, set
//     by the fully pipelined 33x33 multiplier array (sixteen per product unit).
//   Stall: each stage holds its contents while the next stage is full and
//     stalled; bubbles are squeezed out, so s_tready stays high until all
//     seven stages hold requests.
//   Reset: aresetn (synchronous, active low) clears all valid bits; data
//     registers are not reset. No state is carried between requests.
module quaternion_arithmetic_unit import qau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (32b each)
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // r_w, r_x, r_y, r_z (32b each)
    output logic         m_tuser    // saturated
);

    // ---------------- stage 0: operand prep ----------------
    q_t      in_a [4];
    q_t      in_b [4];
    opcode_t in_op;
    logic    v0_reg;
    logic    ready0;
    qw_t     p0_reg [4];
    qw_t     q0_reg [4];
    side_t   side0_reg;
    qw_t     q0_next [4];
    side_t   side0_next;
    sat_t    add_sat [4];

    logic    h1_in_ready, h1_out_valid;
    acc_t    h1_r [4];
    side_t   h1_side;
    logic    ready1;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_a[i] = s_tdata[32*i +: 32];
            in_b[i] = s_tdata[128 + 32*i +: 32];
        end
        in_op = opcode_t'(s_tuser);
    end

    // q operand: b, conj(b), or pure vector (0, b_x, b_y, b_z)
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q0_next[i] = qw_t'(in_b[i]);
            if (i != 0 && in_op == OP_MUL_CONJ) begin
                q0_next[i] = -qw_t'(in_b[i]);
            end
        end
        if (in_op == OP_ROTATE) q0_next[0] = '0;
    end

    // the sum needs no multiply; finish it here and carry it along
    always_comb begin
        side0_next.op   = in_op;
        side0_next.flag = 1'b0;
        for (int i = 0; i < 4; i++) begin
            add_sat[i]         = sat32(acc_t'(in_a[i]) + acc_t'(in_b[i]));
            side0_next.a[i]    = in_a[i];
            side0_next.res[i]  = add_sat[i].val;
            side0_next.flag    = side0_next.flag | add_sat[i].clip;
        end
    end

    assign ready0   = !v0_reg || h1_in_ready;
    assign s_tready = ready0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (ready0) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready0 && s_tvalid) begin
            for (int i = 0; i < 4; i++) begin
                p0_reg[i] <= qw_t'(in_a[i]);
            end
            q0_reg    <= q0_next;
            side0_reg <= side0_next;
        end
    end

    // ---------------- first product: a*q ----------------
    qau_hprod u_hprod_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0_reg),
        .in_ready  (h1_in_ready),
        .p         (p0_reg),
        .q         (q0_reg),
        .side_in   (side0_reg),
        .out_valid (h1_out_valid),
        .out_ready (ready1),
        .r         (h1_r),
        .side_out  (h1_side)
    );

    // ---------------- stage 1: saturate, prep second product ----------------
    logic  v1_reg;
    qw_t   p1_reg [4];
    qw_t   q1_reg [4];
    side_t side1_reg;
    sat_t  t_sat [4];
    qw_t   p1_next [4];
    qw_t   q1_next [4];
    side_t side1_next;
    logic  t_clip;

    logic  h2_in_ready, h2_out_valid;
    acc_t  h2_r [4];
    side_t h2_side;
    logic  ready2;

    always_comb begin
        t_clip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            t_sat[i]   = sat32(h1_r[i]);
            t_clip     = t_clip | t_sat[i].clip;
            p1_next[i] = qw_t'(t_sat[i].val);
            // conj(a), negated at 33 bits so the most negative value is exact
            q1_next[i] = (i == 0) ? qw_t'(h1_side.a[i]) : -qw_t'(h1_side.a[i]);
        end
        side1_next = h1_side;
        if (h1_side.op != OP_ADD) begin
            // product result is final for the two product opcodes; for
            // rotation it is the clipped intermediate t, whose clip counts
            for (int i = 0; i < 4; i++) begin
                side1_next.res[i] = t_sat[i].val;
            end
            side1_next.flag = t_clip;
        end
    end

    assign ready1 = !v1_reg || h2_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ready1) begin
            v1_reg <= h1_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && h1_out_valid) begin
            p1_reg    <= p1_next;
            q1_reg    <= q1_next;
            side1_reg <= side1_next;
        end
    end

    // ---------------- second product: t*conj(a) ----------------
    qau_hprod u_hprod_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (h2_in_ready),
        .p         (p1_reg),
        .q         (q1_reg),
        .side_in   (side1_reg),
        .out_valid (h2_out_valid),
        .out_ready (ready2),
        .r         (h2_r),
        .side_out  (h2_side)
    );

    // ---------------- stage 2: final select and output register ----------------
    logic         m_valid_reg;
    logic [127:0] m_data_reg;
    logic         m_sat_reg;
    logic [127:0] m_data_next;
    logic         m_sat_next;
    sat_t         f_sat [4];

    always_comb begin
        m_sat_next = h2_side.flag;
        for (int i = 0; i < 4; i++) begin
            f_sat[i]            = sat32(h2_r[i]);
            m_data_next[32*i +: 32] = h2_side.res[i];
        end
        if (h2_side.op == OP_ROTATE) begin
            // rotation scalar is dropped; its clip does not count
            m_data_next[31:0] = '0;
            for (int i = 1; i < 4; i++) begin
                m_data_next[32*i +: 32] = f_sat[i].val;
                m_sat_next              = m_sat_next | f_sat[i].clip;
            end
        end
    end

    assign ready2 = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ready2) begin
            m_valid_reg <= h2_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && h2_out_valid) begin
            m_data_reg <= m_data_next;
            m_sat_reg  <= m_sat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule
